// ----- rtl/core/cph_pkg.sv -----
// ----------------------------------------------------------------------------
// cph_pkg
// Shared types, constants and elaboration-time table functions for the
// color harmony palette.
// ----------------------------------------------------------------------------
package cph_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int HUE_FULL          = 5760;
    localparam int VARIANTS          = 11;
    localparam logic [3:0] LAST_K    = 4'(VARIANTS - 1);

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_DONE
    } t_front_state;

    function automatic logic [12:0] hue_off(logic [3:0] k);
        logic [12:0] o;
        case (k)
            4'd1:    o = 13'd2880;
            4'd2:    o = 13'd400;
            4'd3:    o = 13'd5360;
            4'd4:    o = 13'd1920;
            4'd5:    o = 13'd3840;
            default: o = 13'd0;
        endcase
        return o;
    endfunction

    function automatic logic signed [2:0] light_step(logic [3:0] k);
        logic signed [2:0] o;
        case (k)
            4'd6:    o = -3'sd2;
            4'd7:    o = -3'sd1;
            4'd9:    o = 3'sd1;
            4'd10:   o = 3'sd2;
            default: o = 3'sd0;
        endcase
        return o;
    endfunction

    function automatic longint unsigned mq30(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned pow5q30(longint unsigned r);
        longint unsigned r2;
        longint unsigned r4;
        r2 = mq30(r, r);
        r4 = mq30(r2, r2);
        return mq30(r4, r);
    endfunction

    // sRGB linearization of one 8-bit channel, fb fraction bits
    function automatic longint unsigned lin_f(int c, int fb);
        longint unsigned one;
        longint unsigned y;
        longint unsigned y2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned l30;
        one = 64'd1 << fb;
        if (c <= 10) begin
            return (2 * 100 * longint'(c) * one + 329460) / (2 * 329460);
        end
        y  = (2 * ((longint'(1000 * c + 14025)) << 30) + 269025) / (2 * 269025);
        y2 = mq30(y, y);
        lo = 0;
        hi = 64'd1 << 30;
        for (int i = 0; i < 40; i++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (pow5q30(mid) <= y2) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        l30 = mq30(y2, lo);
        return (l30 + (64'd1 << (29 - fb))) >> (30 - fb);
    endfunction

    // weighted luminance sum at or above this picks black text
    function automatic longint unsigned black_thr(int fb);
        longint unsigned one;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        one = 64'd1 << fb;
        lo  = 0;
        hi  = one;
        for (int i = 0; i < 40; i++) begin
            if (lo < hi) begin
                mid = (lo + hi) / 2;
                if ((20 * mid + one) * (20 * mid + one) >= 21 * one * one) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
        end
        return 10000 * lo - 5000;
    endfunction

endpackage

// ----- rtl/core/cph_div.sv -----
// ----------------------------------------------------------------------------
// cph_div
// Radix-16 restoring divider, four quotient bits per cycle, 11-bit divisor.
// ----------------------------------------------------------------------------
module cph_div #(
    parameter int NW = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [10:0]   i_den,
    output logic [NW-1:0] o_quo,
    output logic          o_busy
);

    localparam int STEPS = (NW + 3) / 4;
    localparam int NP    = STEPS * 4;
    localparam int CW    = $clog2(STEPS + 1);

    logic [NP-1:0] r_num, n_num;
    logic [10:0]   r_rem, n_rem;
    logic [10:0]   r_den;
    logic [CW-1:0] r_cnt;

    always_comb begin
        logic [11:0] sh;
        n_num = r_num;
        n_rem = r_rem;
        for (int i = 0; i < 4; i++) begin
            sh    = {n_rem, n_num[NP-1]};
            n_num = {n_num[NP-2:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                sh       = sh - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
            n_rem = sh[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NP'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_quo  = r_num[NW-1:0];
    assign o_busy = (r_cnt != '0);

endmodule

// ----- rtl/core/cph_front.sv -----
// ----------------------------------------------------------------------------
// cph_front
// Accept a base color and convert it to hue, saturation and lightness
// with three dividers running side by side.
// ----------------------------------------------------------------------------
module cph_front #(
    parameter int FB = cph_pkg::FRACTION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [7:0]   i_red,
    input  logic [7:0]   i_green,
    input  logic [7:0]   i_blue,
    output logic         o_push,
    input  logic         i_full,
    output logic [12:0]  o_h,
    output logic [FB:0]  o_s,
    output logic [FB:0]  o_l
);

    localparam int NW = (FB + 10 > 22) ? FB + 10 : 22;

    cph_pkg::t_front_state r_state, n_state;
    logic          accept;
    logic [7:0]    mx, mn, d;
    logic [8:0]    sum, den;
    logic signed [23:0] nh;
    logic [NW-1:0] num_h, num_s, num_l;
    logic [10:0]   den_h, den_s;
    logic [NW-1:0] quo_h, quo_s, quo_l;
    logic          busy_h, busy_s, busy_l;
    logic          r_achrom;
    logic [12:0]   q13;
    logic [12:0]   r_h;
    logic [FB:0]   r_s, r_l;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        den = (sum <= 9'd255) ? sum : 9'd510 - sum;
        priority if (mx == i_red) begin
            nh = 24'sd960 * ($signed({16'd0, i_green}) - $signed({16'd0, i_blue}))
                 + 24'sd5760 * $signed({16'd0, d});
        end else if (mx == i_green) begin
            nh = 24'sd960 * ($signed({16'd0, i_blue}) - $signed({16'd0, i_red}))
                 + 24'sd1920 * $signed({16'd0, d});
        end else begin
            nh = 24'sd960 * ($signed({16'd0, i_red}) - $signed({16'd0, i_green}))
                 + 24'sd3840 * $signed({16'd0, d});
        end
        num_h = NW'({nh[22:0], 1'b0}) + NW'(d);
        num_s = (NW'(d) << (FB + 1)) + NW'(den);
        num_l = (NW'(sum) << (FB + 1)) + NW'(510);
        den_h = (d == 8'd0) ? 11'd1 : {2'b0, d, 1'b0};
        den_s = (d == 8'd0) ? 11'd1 : {1'b0, den, 1'b0};
    end

    cph_div #(.NW(NW)) u_div_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_num(num_h), .i_den(den_h), .o_quo(quo_h), .o_busy(busy_h)
    );
    cph_div #(.NW(NW)) u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_num(num_s), .i_den(den_s), .o_quo(quo_s), .o_busy(busy_s)
    );
    cph_div #(.NW(NW)) u_div_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_num(num_l), .i_den(11'd1020), .o_quo(quo_l), .o_busy(busy_l)
    );

    assign q13 = quo_h[12:0];

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            cph_pkg::FS_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = cph_pkg::FS_DIV;
            end
            cph_pkg::FS_DIV: begin
                if (!(busy_h || busy_s || busy_l)) n_state = cph_pkg::FS_DONE;
            end
            cph_pkg::FS_DONE: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    o_ready = 1'b1;
                    n_state = i_valid ? cph_pkg::FS_DIV : cph_pkg::FS_IDLE;
                end
            end
            default: n_state = cph_pkg::FS_IDLE;
        endcase
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cph_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_achrom <= (d == 8'd0);
        if (r_state == cph_pkg::FS_DIV && !(busy_h || busy_s || busy_l)) begin
            r_l <= quo_l[FB:0];
            r_s <= r_achrom ? '0 : quo_s[FB:0];
            if (r_achrom) begin
                r_h <= '0;
            end else if (q13 >= 13'(cph_pkg::HUE_FULL)) begin
                r_h <= q13 - 13'(cph_pkg::HUE_FULL);
            end else begin
                r_h <= q13;
            end
        end
    end

    assign o_h = r_h;
    assign o_s = r_s;
    assign o_l = r_l;

endmodule

// ----- rtl/core/cph_queue.sv -----
// ----------------------------------------------------------------------------
// cph_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module cph_queue #(
    parameter int W = 47
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

// ----- rtl/core/cph_back.sv -----
// ----------------------------------------------------------------------------
// cph_back
// Issue eleven variants per color and run each through HSL to RGB conversion
// and the black/white text pick, one variant per cycle while not stalled.
// ----------------------------------------------------------------------------
module cph_back #(
    parameter int FB = cph_pkg::FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_pop,
    input  logic [12:0] i_h,
    input  logic [FB:0] i_s,
    input  logic [FB:0] i_l,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_white,
    output logic        o_last
);

    localparam int LW  = FB + 1;
    localparam int SW  = FB + 4;
    localparam int VW  = FB + 16;
    localparam int XW  = FB + 26;
    localparam int YW  = LW + 14;
    localparam longint ONE = 64'sd1 << FB;
    localparam longint D30 = (6 * ONE + 10) / 20;
    localparam longint D15 = (6 * ONE + 20) / 40;
    localparam longint unsigned KTHR = cph_pkg::black_thr(FB);

    logic [LW-1:0] lin_tab [256];
    for (genvar gi = 0; gi < 256; gi++) begin : g_lin
        assign lin_tab[gi] = LW'(cph_pkg::lin_f(gi, FB));
    end

    logic adv, issue;
    logic [3:0] r_k;

    // stage registers
    logic [8:1] r_v;
    logic [3:0] r_idx [1:8];
    logic [12:0] r1_hv;
    logic [LW-1:0] r1_lv, r1_s, r2_lv, r2_s, r2_ls;
    logic [12:0] r2_hv;
    logic signed [SW-1:0] r3_p, r3_q;
    logic [12:0] r3_t [3];
    logic [VW-2:0] r4_v [3];
    logic [11:0] r5_x [3];
    logic [7:0] r6_c [3], r7_c [3], r8_c [3];
    logic [LW-1:0] r7_lin [3];
    logic [YW-1:0] r8_y;

    assign adv   = !r_v[8] || i_ready;
    assign issue = adv && i_valid;
    assign o_pop = issue && (r_k == cph_pkg::LAST_K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[7:1], issue};
            if (issue) r_k <= (r_k == cph_pkg::LAST_K) ? 4'd0 : r_k + 4'd1;
        end
    end

    // stage 1: hue offset and lightness step
    logic [13:0] hsum;
    logic signed [SW-1:0] lvx, dl;
    always_comb begin
        hsum = {1'b0, i_h} + {1'b0, cph_pkg::hue_off(r_k)};
        if (hsum >= 14'(cph_pkg::HUE_FULL)) hsum = hsum - 14'(cph_pkg::HUE_FULL);
        unique case (cph_pkg::light_step(r_k))
            -3'sd2:  dl = -SW'(D30);
            -3'sd1:  dl = -SW'(D15);
            3'sd1:   dl = SW'(D15);
            3'sd2:   dl = SW'(D30);
            default: dl = '0;
        endcase
        lvx = $signed(SW'(i_l)) + dl;
        if (lvx < 0) lvx = '0;
        else if (lvx > SW'(ONE)) lvx = SW'(ONE);
    end

    // stage 2: l*s
    logic [2*LW-1:0] prod;
    assign prod = (2*LW)'(r1_lv) * (2*LW)'(r1_s) + (2*LW)'(ONE / 2);

    // stage 3: q, p and channel hues
    logic signed [SW-1:0] q2, p2;
    logic [13:0] tr, tb;
    always_comb begin
        if ({r2_lv, 1'b0} < (LW + 1)'(ONE)) begin
            q2 = $signed(SW'(r2_lv)) + $signed(SW'(r2_ls));
        end else begin
            q2 = $signed(SW'(r2_lv)) + $signed(SW'(r2_s)) - $signed(SW'(r2_ls));
        end
        p2 = $signed(SW'({r2_lv, 1'b0})) - q2;
        tr = {1'b0, r2_hv} + 14'd1920;
        if (tr >= 14'(cph_pkg::HUE_FULL)) tr = tr - 14'(cph_pkg::HUE_FULL);
        tb = {1'b0, r2_hv} + 14'd3840;
        if (tb >= 14'(cph_pkg::HUE_FULL)) tb = tb - 14'(cph_pkg::HUE_FULL);
    end

    // stage 4: piecewise ramp, v = 960p + (q-p)*tt
    logic signed [VW-1:0] v3 [3];
    always_comb begin
        logic [12:0] tt;
        logic signed [SW-1:0] df;
        df = r3_q - r3_p;
        for (int c = 0; c < 3; c++) begin
            priority if (r3_t[c] < 13'd960) tt = r3_t[c];
            else if (r3_t[c] < 13'd2880)    tt = 13'd960;
            else if (r3_t[c] < 13'd3840)    tt = 13'd3840 - r3_t[c];
            else                            tt = 13'd0;
            v3[c] = VW'(r3_p) * VW'(960) + VW'(df) * $signed({{(VW-13){1'b0}}, tt});
        end
    end

    // stage 5: scale to 15 times 0..255, clamped to 4095, before the divide by 15
    logic [11:0] x4 [3];
    always_comb begin
        logic [XW-1:0] xx;
        for (int c = 0; c < 3; c++) begin
            xx = XW'(r4_v[c]) * XW'(510) + (XW'(960) << FB);
            x4[c] = (xx[XW-1:FB+7] > (XW-FB-7)'(4095)) ? 12'd4095 : xx[FB+18:FB+7];
        end
    end

    // stage 6: divide by 15 with a reciprocal
    logic [7:0] c5 [3];
    always_comb begin
        logic [25:0] m;
        for (int c = 0; c < 3; c++) begin
            m = 26'(r5_x[c]) * 26'd8739;
            c5[c] = (m[25:17] > 9'd255) ? 8'd255 : m[24:17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_idx[1] <= r_k;
            for (int i = 2; i <= 8; i++) r_idx[i] <= r_idx[i-1];
            r1_hv <= hsum[12:0];
            r1_lv <= lvx[LW-1:0];
            r1_s  <= i_s;
            r2_hv <= r1_hv;
            r2_lv <= r1_lv;
            r2_s  <= r1_s;
            r2_ls <= prod[FB+LW-1:FB];
            r3_p  <= p2;
            r3_q  <= q2;
            r3_t[0] <= tr[12:0];
            r3_t[1] <= r2_hv;
            r3_t[2] <= tb[12:0];
            for (int c = 0; c < 3; c++) begin
                r4_v[c]   <= (v3[c] < 0) ? '0 : v3[c][VW-2:0];
                r5_x[c]   <= x4[c];
                r6_c[c]   <= c5[c];
                r7_c[c]   <= r6_c[c];
                r7_lin[c] <= lin_tab[r6_c[c]];
                r8_c[c]   <= r7_c[c];
            end
            r8_y <= YW'(r7_lin[0]) * YW'(2126) + YW'(r7_lin[1]) * YW'(7152)
                    + YW'(r7_lin[2]) * YW'(722);
        end
    end

    assign o_valid = r_v[8];
    assign o_index = r_idx[8];
    assign o_red   = r8_c[0];
    assign o_green = r8_c[1];
    assign o_blue  = r8_c[2];
    assign o_white = !(r8_y >= YW'(KTHR));
    assign o_last  = (r_idx[8] == cph_pkg::LAST_K);

endmodule

// ----- rtl/core/color_harmony_palette.sv -----
// ----------------------------------------------------------------------------
// color_harmony_palette
// Eleven-color harmony palette with black/white text pick per color.
// ----------------------------------------------------------------------------
// One request carries an 8-bit RGB base color. The block answers with eleven
// variants in order: base, complement, two analogs, two triadics and five
// shades, one variant per cycle while the output side is ready. The front
// end converts each color in its three radix-16 dividers and overlaps with
// the back end through a two-entry queue; the back end holds eight pipeline
// stages.
module color_harmony_palette #(
    parameter int FRACTION_BITS = cph_pkg::FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_base_red,
    input  logic [7:0] i_base_green,
    input  logic [7:0] i_base_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_variant_index,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic       o_text_white,
    output logic       o_last_variant
);

    localparam int QW = 13 + 2 * (FRACTION_BITS + 1);

    logic                   push, full, pop, q_valid;
    logic [12:0]            f_h;
    logic [FRACTION_BITS:0] f_s, f_l;
    logic [QW-1:0]          q_data;

    cph_front #(.FB(FRACTION_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_red(i_base_red), .i_green(i_base_green), .i_blue(i_base_blue),
        .o_push(push), .i_full(full),
        .o_h(f_h), .o_s(f_s), .o_l(f_l)
    );

    cph_queue #(.W(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data({f_h, f_s, f_l}), .o_full(full),
        .i_pop(pop), .o_valid(q_valid), .o_data(q_data)
    );

    cph_back #(.FB(FRACTION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_pop(pop),
        .i_h(q_data[QW-1 -: 13]),
        .i_s(q_data[2*FRACTION_BITS+1 : FRACTION_BITS+1]),
        .i_l(q_data[FRACTION_BITS:0]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_index(o_variant_index),
        .o_red(o_out_red), .o_green(o_out_green), .o_blue(o_out_blue),
        .o_white(o_text_white), .o_last(o_last_variant)
    );

endmodule
